// File: rtl/core/rau_pkg.sv
package rau_pkg;

	// default operand width
	localparam int WIDTH_DEF = 32;

	// queue depth between front and back
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_INVAL = 2'd1,
		ST_DIVZ  = 2'd2,
		ST_OVF   = 2'd3
	} st_t;

	// which fraction a reduction belongs to
	typedef enum logic [1:0] {
		PH_A,
		PH_B,
		PH_R
	} phase_t;

	typedef enum logic [1:0] {
		R_IDLE,
		R_GCD,
		R_DIVM,
		R_DIVD
	} red_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_RED,
		B_RWAIT,
		B_NEXT,
		B_MUL1,
		B_MUL2,
		B_MUL3,
		B_COMB,
		B_FIT
	} back_state_t;

	// queue handshake toward the back end
	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

endpackage

// File: rtl/core/rau_front.sv
module rau_front #(
	parameter int W = rau_pkg::WIDTH_DEF
) (
	input  logic              start,
	input  logic              full,
	input  logic [1:0]        cmd,
	input  logic [31:0]       lhs_num,
	input  logic [31:0]       lhs_den,
	input  logic [31:0]       rhs_num,
	input  logic [31:0]       rhs_den,
	output logic              push,
	output logic [4*W+4:0]    entry
);
	import rau_pkg::*;

	logic [W-1:0] ln_v, ld_v, rn_v, rd_v;
	logic [W-1:0] ln_m, ld_m, rn_m, rd_m;
	logic         inval;
	logic         a_neg, b_neg;

	// take low W bits as two's complement, split into sign and magnitude
	assign ln_v = lhs_num[W-1:0];
	assign ld_v = lhs_den[W-1:0];
	assign rn_v = rhs_num[W-1:0];
	assign rd_v = rhs_den[W-1:0];

	assign ln_m = ln_v[W-1] ? (~ln_v + 1'b1) : ln_v;
	assign ld_m = ld_v[W-1] ? (~ld_v + 1'b1) : ld_v;
	assign rn_m = rn_v[W-1] ? (~rn_v + 1'b1) : rn_v;
	assign rd_m = rd_v[W-1] ? (~rd_v + 1'b1) : rd_v;

	// classify: zero denominator is an invalid argument
	assign inval = (ld_v == '0) || (rd_v == '0);
	assign a_neg = ln_v[W-1] ^ ld_v[W-1];
	assign b_neg = rn_v[W-1] ^ rd_v[W-1];

	assign push  = start & ~full;
	assign entry = {cmd, inval, a_neg, ln_m, ld_m, b_neg, rn_m, rd_m};

endmodule

// File: rtl/core/rau_queue.sv
module rau_queue #(
	parameter int DW = 133
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [DW-1:0]       wdata,
	input  logic                pop,
	output logic [DW-1:0]       rdata,
	output rau_pkg::q_stat_t    stat
);
	import rau_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	logic [DW-1:0] mem_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign rdata      = mem_q[rp_q];
	assign stat.valid = (cnt_q != '0);
	assign stat.full  = (cnt_q == CW'(QDEPTH));

endmodule

// File: rtl/core/rau_reduce.sv
module rau_reduce #(
	parameter int RW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [RW-1:0] mag,
	input  logic [RW-1:0] den,
	output logic          done,
	output logic [RW-1:0] rmag,
	output logic [RW-1:0] rden
);
	import rau_pkg::*;

	localparam int CW = $clog2(RW + 1);

	red_state_t    state_q, state_d;
	logic [RW-1:0] ga_q, gb_q, g_q, mag_q, den_q, dq_q, rem_q, rmag_q;
	logic [CW-1:0] gk_q, cnt_q;
	logic          done_q;

	logic          g_end;
	logic [RW:0]   sh, diff;
	logic          ge;
	logic [RW-1:0] rem_n, dq_n;

	// binary gcd finishes when one side reaches zero
	assign g_end = (ga_q == '0) || (gb_q == '0);

	// one restoring divide step per cycle
	assign sh    = {rem_q, dq_q[RW-1]};
	assign diff  = sh - {1'b0, g_q};
	assign ge    = ~diff[RW];
	assign rem_n = ge ? diff[RW-1:0] : sh[RW-1:0];
	assign dq_n  = {dq_q[RW-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == R_DIVD) && (cnt_q == CW'(1));
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			R_IDLE: if (start) state_d = R_GCD;
			R_GCD:  if (g_end) state_d = R_DIVM;
			R_DIVM: if (cnt_q == CW'(1)) state_d = R_DIVD;
			R_DIVD: if (cnt_q == CW'(1)) state_d = R_IDLE;
			default: state_d = R_IDLE;
		endcase
	end

	// gcd and divide datapath
	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				if (start) begin
					ga_q  <= mag;
					gb_q  <= den;
					gk_q  <= '0;
					mag_q <= mag;
					den_q <= den;
				end
			end
			R_GCD: begin
				if (g_end) begin
					g_q   <= (ga_q | gb_q) << gk_q;
					dq_q  <= mag_q;
					rem_q <= '0;
					cnt_q <= CW'(RW);
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					gk_q <= gk_q + 1'b1;
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q >= gb_q) begin
					ga_q <= ga_q - gb_q;
				end else begin
					gb_q <= gb_q - ga_q;
				end
			end
			R_DIVM: begin
				if (cnt_q == CW'(1)) begin
					rmag_q <= dq_n;
					dq_q   <= den_q;
					rem_q  <= '0;
					cnt_q  <= CW'(RW);
				end else begin
					dq_q  <= dq_n;
					rem_q <= rem_n;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			R_DIVD: begin
				dq_q  <= dq_n;
				rem_q <= rem_n;
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign rmag = rmag_q;
	assign rden = dq_q;

endmodule

// File: rtl/core/rau_back.sv
module rau_back #(
	parameter int W = rau_pkg::WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  logic [4*W+4:0]   q_data,
	output logic             pop,
	output logic             done,
	output logic [31:0]      result_num,
	output logic [30:0]      result_den,
	output logic [1:0]       status
);
	import rau_pkg::*;

	localparam int RW = 2 * W;
	localparam int EW = 4 * W + 5;

	back_state_t   state_q, state_d;
	phase_t        ph_q;
	logic [EW-1:0] e_q;

	logic          cur_neg_q, a_neg_q, b_neg_q, r_neg_q;
	logic [RW-1:0] cur_mag_q, cur_den_q;
	logic [RW-1:0] a_mag_q, a_den_q, b_mag_q, b_den_q, r_mag_q, r_den_q;
	logic [RW-1:0] m1_q, m2_q, pd_q;

	logic          done_q;
	st_t           status_q;
	logic [31:0]   num_q;
	logic [30:0]   den_q;

	logic          red_start, red_done;
	logic [RW-1:0] red_mag, red_den;
	logic          emit;
	st_t           emit_st;

	logic          wr_en, wr_neg;
	logic [RW-1:0] wr_mag, wr_den;

	logic [1:0]    e_cmd;
	logic          q_inv;
	logic [W-1:0]  mul_x, mul_y;
	logic [RW-1:0] prod;

	logic          s1, s2, c_neg;
	logic [RW-1:0] c_mag;
	logic          fits;
	logic [RW-1:0] limit;
	logic [31:0]   mag32;

	// entry fields
	assign e_cmd = e_q[EW-1 -: 2];
	assign q_inv = q_data[EW-3];

	rau_reduce #(.RW(RW)) u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.mag    (cur_mag_q),
		.den    (cur_den_q),
		.done   (red_done),
		.rmag   (red_mag),
		.rden   (red_den)
	);

	// shared multiplier, operands chosen by step
	always_comb begin
		mul_x = a_mag_q[W-1:0];
		mul_y = b_den_q[W-1:0];
		case (state_q)
			B_MUL1: begin
				mul_x = a_mag_q[W-1:0];
				mul_y = (e_cmd == CMD_MUL) ? b_mag_q[W-1:0] : b_den_q[W-1:0];
			end
			B_MUL2: begin
				mul_x = b_mag_q[W-1:0];
				mul_y = a_den_q[W-1:0];
			end
			B_MUL3: begin
				mul_x = a_den_q[W-1:0];
				mul_y = (e_cmd == CMD_DIV) ? b_mag_q[W-1:0] : b_den_q[W-1:0];
			end
			default: ;
		endcase
	end
	assign prod = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};

	// signed combine of the products
	always_comb begin
		s1    = a_neg_q;
		s2    = (e_cmd == CMD_SUB) ? ~b_neg_q : b_neg_q;
		c_neg = a_neg_q ^ b_neg_q;
		c_mag = m1_q;
		if (e_cmd == CMD_ADD || e_cmd == CMD_SUB) begin
			if (m2_q == '0) s2 = s1;
			if (m1_q == '0) s1 = s2;
			if (s1 == s2) begin
				c_neg = s1;
				c_mag = m1_q + m2_q;
			end else if (m1_q >= m2_q) begin
				c_neg = s1;
				c_mag = m1_q - m2_q;
			end else begin
				c_neg = s2;
				c_mag = m2_q - m1_q;
			end
		end
	end

	// range check of the reduced result
	assign limit = RW'(1) << (W - 1);
	assign fits  = (r_den_q <= limit - 1'b1) &&
	               (r_neg_q ? (r_mag_q <= limit) : (r_mag_q <= limit - 1'b1));
	assign mag32 = 32'(r_mag_q);

	// write-back of a reduced fraction
	always_comb begin
		wr_en  = 1'b0;
		wr_neg = cur_neg_q;
		wr_mag = red_mag;
		wr_den = red_den;
		if (state_q == B_RED && cur_mag_q == '0) begin
			wr_en  = 1'b1;
			wr_neg = 1'b0;
			wr_mag = '0;
			wr_den = RW'(1);
		end else if (state_q == B_RWAIT && red_done) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		red_start = 1'b0;
		emit      = 1'b0;
		emit_st   = ST_OK;
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					if (q_inv) begin
						emit    = 1'b1;
						emit_st = ST_INVAL;
					end else begin
						state_d = B_RED;
					end
				end
			end
			B_RED: begin
				if (cur_mag_q == '0) begin
					state_d = B_NEXT;
				end else begin
					red_start = 1'b1;
					state_d   = B_RWAIT;
				end
			end
			B_RWAIT: if (red_done) state_d = B_NEXT;
			B_NEXT: begin
				case (ph_q)
					PH_A: state_d = B_RED;
					PH_B: begin
						if (e_cmd == CMD_DIV && b_mag_q == '0) begin
							emit    = 1'b1;
							emit_st = ST_DIVZ;
							state_d = B_IDLE;
						end else begin
							state_d = B_MUL1;
						end
					end
					default: state_d = B_FIT;
				endcase
			end
			B_MUL1: state_d = B_MUL2;
			B_MUL2: state_d = B_MUL3;
			B_MUL3: state_d = B_COMB;
			B_COMB: state_d = B_RED;
			B_FIT: begin
				emit    = 1'b1;
				emit_st = fits ? ST_OK : ST_OVF;
				state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// operand, product and result registers
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && q_valid) begin
			e_q       <= q_data;
			ph_q      <= PH_A;
			cur_neg_q <= q_data[EW-4];
			cur_mag_q <= {{W{1'b0}}, q_data[EW-5 -: W]};
			cur_den_q <= {{W{1'b0}}, q_data[EW-5-W -: W]};
		end
		if (state_q == B_NEXT && ph_q == PH_A) begin
			ph_q      <= PH_B;
			cur_neg_q <= e_q[2*W];
			cur_mag_q <= {{W{1'b0}}, e_q[2*W-1 -: W]};
			cur_den_q <= {{W{1'b0}}, e_q[W-1:0]};
		end
		if (wr_en) begin
			case (ph_q)
				PH_A: begin
					a_neg_q <= wr_neg;
					a_mag_q <= wr_mag;
					a_den_q <= wr_den;
				end
				PH_B: begin
					b_neg_q <= wr_neg;
					b_mag_q <= wr_mag;
					b_den_q <= wr_den;
				end
				default: begin
					r_neg_q <= wr_neg;
					r_mag_q <= wr_mag;
					r_den_q <= wr_den;
				end
			endcase
		end
		if (state_q == B_MUL1) m1_q <= prod;
		if (state_q == B_MUL2) m2_q <= prod;
		if (state_q == B_MUL3) pd_q <= prod;
		if (state_q == B_COMB) begin
			ph_q      <= PH_R;
			cur_neg_q <= c_neg;
			cur_mag_q <= c_mag;
			cur_den_q <= pd_q;
		end
		if (emit) begin
			status_q <= emit_st;
			if (emit_st == ST_OK) begin
				num_q <= r_neg_q ? (32'd0 - mag32) : mag32;
				den_q <= 31'(r_den_q);
			end else begin
				num_q <= '0;
				den_q <= '0;
			end
		end
	end

	assign done       = done_q;
	assign result_num = num_q;
	assign result_den = den_q;
	assign status     = status_q;

endmodule

// File: rtl/core/rational_arithmetic_unit.sv
// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+------------------------------
// command  | cmd, lhs_num, lhs_den, rhs_num, rhs_den      | taken when start & !busy
// result   | result_num, result_den, status               | done high for one cycle
//
// Each transaction runs up to three reductions (left, right, result), each a
// binary gcd of one subtract or shift per cycle followed by two restoring
// divisions, of the magnitude and then of the denominator by the gcd.
// A two-entry queue lets commands be taken while the back end works; busy is
// high while it is full. Reset is asynchronous and empties queue and sequencer.
// The result channel has no back-pressure.
module rational_arithmetic_unit #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] lhs_num,
	input  logic [31:0] lhs_den,
	input  logic [31:0] rhs_num,
	input  logic [31:0] rhs_den,
	output logic        done,
	output logic [31:0] result_num,
	output logic [30:0] result_den,
	output logic [1:0]  status
);
	import rau_pkg::*;

	localparam int EW = 4 * WIDTH + 5;

	logic          push, pop;
	logic [EW-1:0] entry, q_data;
	q_stat_t       q_stat;

	assign busy = q_stat.full;

	rau_front #(.W(WIDTH)) u_front (
		.start   (start),
		.full    (q_stat.full),
		.cmd     (cmd),
		.lhs_num (lhs_num),
		.lhs_den (lhs_den),
		.rhs_num (rhs_num),
		.rhs_den (rhs_den),
		.push    (push),
		.entry   (entry)
	);

	rau_queue #(.DW(EW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (pop),
		.rdata  (q_data),
		.stat   (q_stat)
	);

	rau_back #(.W(WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_stat.valid),
		.q_data     (q_data),
		.pop        (pop),
		.done       (done),
		.result_num (result_num),
		.result_den (result_den),
		.status     (status)
	);

endmodule
